>>> sv/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared sizes, item types, command codes and states of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned BITS_PER_BITMAP  = 8192;
  localparam int unsigned MAX_BITMAPS      = 8;
  localparam int unsigned WORD_BITS        = 32;

  localparam int unsigned TOTAL_BITS       = BITS_PER_BITMAP * MAX_BITMAPS;
  localparam int unsigned TOTAL_WORDS      = TOTAL_BITS / WORD_BITS;
  localparam int unsigned WORDS_PER_BITMAP = BITS_PER_BITMAP / WORD_BITS;

  localparam int unsigned WIDX_W = $clog2(TOTAL_WORDS);
  localparam int unsigned BIDX_W = $clog2(WORD_BITS);
  localparam int unsigned LIM_W  = WIDX_W + 1;

  localparam int unsigned BLK_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned BMC_W   = 4;
  localparam int unsigned WIN_W   = 11;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST  = 17'h10000;
  localparam logic [BMC_W-1:0] BITMAP_COUNT_RST = 4'd8;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_LOAD,
    CMD_SET_COUNT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_e;

  typedef enum logic {
    REG_BLOCK_COUNT,
    REG_BITMAP_COUNT
  } reg_e;

  typedef struct packed {
    cmd_e              command;
    logic [BLK_W-1:0]  block_number;
    logic [WIN_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
    logic [CNT_W-1:0]  count_value;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [BLK_W-1:0]  granted_block;
    logic [CNT_W-1:0]  free_blocks;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] block_count;
    logic [BMC_W-1:0] bitmap_count;
  } cfg_t;

  function automatic logic [BIDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

>>> sv/bba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/bba_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator configuration registers
// APB register file holding the block count and the number of bitmaps.
// ----------------------------------------------------------------------------
module bba_cfg
  import bba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_BLOCK_COUNT:  cfg_d.block_count  = pwdata[CNT_W-1:0];
        REG_BITMAP_COUNT: cfg_d.bitmap_count = pwdata[BMC_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_COUNT:  prdata = APB_DW'(cfg_q.block_count);
      REG_BITMAP_COUNT: prdata = APB_DW'(cfg_q.bitmap_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_count  <= BLOCK_COUNT_RST;
      cfg_q.bitmap_count <= BITMAP_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> sv/bitmap_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit block allocator over a usage bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Commands enter on the input channel and each gives exactly one result item
// on the output channel. Both channels use valid and stall; the APB port sets
// the block count and the number of bitmaps searched.
// Load and set-count commands, and an allocate with no bitmap in use, finish
// at acceptance, so their result is valid in the next cycle. Free reads its
// word from the RAM, then writes the word back with the freed bit cleared.
// Allocate reads one bitmap word per cycle from word 0 upward until it finds
// a word with a clear bit or reaches the last word of the bitmaps in use.
// This word scan through the single RAM read port sets the rate.
// One item is in work at a time. The next item is taken while the result
// register is empty or being taken in the same cycle.
// After reset the bitmap RAM is cleared one word per cycle, and the input
// stalls meanwhile; configuration writes are taken throughout.
// A stalled result holds in the output register and the input stalls.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  state_e state_q, state_d;
  logic [WIDX_W-1:0] clr_idx_q, clr_idx_d;
  logic [WIDX_W-1:0] chk_idx_q, chk_idx_d;
  logic [WIDX_W-1:0] fr_addr_q, fr_addr_d;
  logic [BIDX_W-1:0] fr_bit_q, fr_bit_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, res_d;
  logic              res_load;

  logic                 ram_we, ram_re;
  logic [WIDX_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic              acc, out_free;
  logic [BMC_W-1:0]  nb;
  logic [LIM_W-1:0]  lim;
  logic              lim_zero, hit, last, grant_ok;
  logic [BIDX_W-1:0] zpos;
  logic [BLK_W-1:0]  gblk;

  bba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (TOTAL_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  assign nb       = (cfg.bitmap_count > BMC_W'(MAX_BITMAPS)) ? BMC_W'(MAX_BITMAPS)
                                                              : cfg.bitmap_count;
  assign lim      = LIM_W'(nb) * LIM_W'(WORDS_PER_BITMAP);
  assign lim_zero = (lim == '0);
  assign hit      = (ram_rdata != '1);
  assign zpos     = lowest_zero(ram_rdata);
  assign gblk     = BLK_W'({chk_idx_q, zpos});
  assign grant_ok = (CNT_W'(gblk) < cfg.block_count);
  assign last     = ((LIM_W'(chk_idx_q) + LIM_W'(1)) == lim);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == WIDX_W'(TOTAL_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_item_i.command == CMD_ALLOC && !lim_zero) begin
            state_d = ST_SCAN;
          end else if (in_item_i.command == CMD_FREE) begin
            state_d = ST_FREE;
          end
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_d = ST_IDLE;
        end
      end
      ST_FREE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    count_d    = count_q;
    res_load   = 1'b0;
    res_d      = '0;
    clr_idx_d  = clr_idx_q;
    chk_idx_d  = chk_idx_q;
    fr_addr_d  = fr_addr_q;
    fr_bit_d   = fr_bit_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + WIDX_W'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          fr_addr_d = WIDX_W'(in_item_i.block_number >> BIDX_W);
          fr_bit_d  = in_item_i.block_number[BIDX_W-1:0];
          chk_idx_d = '0;
          case (in_item_i.command)
            CMD_ALLOC: begin
              if (lim_zero) begin
                res_load     = 1'b1;
                res_d.status = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
              end
            end
            CMD_FREE: begin
              ram_re    = 1'b1;
              ram_raddr = WIDX_W'(in_item_i.block_number >> BIDX_W);
            end
            CMD_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = in_item_i.word_index[WIDX_W-1:0];
              ram_wdata = in_item_i.word_data[WORD_BITS-1:0];
              res_load  = 1'b1;
            end
            default: begin
              count_d  = in_item_i.count_value;
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_load = 1'b1;
          if (grant_ok) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_q;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << zpos);
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
            res_d.granted_block = gblk;
          end else begin
            res_d.status = 1'b1;
          end
        end else if (last) begin
          res_load     = 1'b1;
          res_d.status = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = chk_idx_q + WIDX_W'(1);
          chk_idx_d = chk_idx_q + WIDX_W'(1);
        end
      end
      ST_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = fr_addr_q;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fr_bit_q);
        if (count_q < cfg.block_count) begin
          count_d = count_q + CNT_W'(1);
        end
        res_load = 1'b1;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    res_d.free_blocks = count_d;
  end

  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    fr_addr_q <= fr_addr_d;
    fr_bit_q  <= fr_bit_d;
    if (res_load) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !out_valid_q)
    else $error("result pending while an item is in work");

  a_fail_grants_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |-> out_q.granted_block == '0)
    else $error("failed allocation reports a block");

  a_free_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_item_i.command == CMD_FREE |=> state_q == ST_FREE && ram_we)
    else $error("free did not write back its word");

  a_scan_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && ram_we |-> grant_ok && res_load)
    else $error("scan wrote a word without granting a block");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Sends allocate, free, load-word and set-count items through the valid/stall
// channels and checks every result, most against a predictor of the usage
// bitmap and free count. A directed table comes first, then random phases
// under several register settings and several patterns of sender and
// receiver idling, including a full bitmap to reach the no-free-block case.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned     END_WAIT    = 2100;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_e        reg_sel;
    logic [31:0] reg_val;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic [WORD_BITS-1:0] usage_words [TOTAL_WORDS];
  logic [CNT_W-1:0]     free_cnt;
  logic [CNT_W-1:0]     block_limit;
  logic [BMC_W-1:0]     bitmaps_used;

  out_item_t       pending_results [$];
  stim_row_t       directed [$];
  int unsigned     errors         = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  longint unsigned cycles         = 0;

  bitmap_block_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  function automatic out_item_t predict_alloc_result(in_item_t it);
    out_item_t   res;
    int unsigned nb;
    int unsigned w;
    int unsigned b;
    int unsigned g;
    bit          found;
    res = '0;
    g = 0;
    found = 1'b0;
    case (it.command)
      CMD_ALLOC: begin
        nb = (bitmaps_used > MAX_BITMAPS) ? MAX_BITMAPS : bitmaps_used;
        for (w = 0; w < nb * WORDS_PER_BITMAP && !found; w++) begin
          if (usage_words[w] != '1) begin
            for (b = 0; b < WORD_BITS && !found; b++) begin
              if (!usage_words[w][b]) begin
                found = 1'b1;
                g = w * WORD_BITS + b;
              end
            end
          end
        end
        if (found && g < block_limit) begin
          usage_words[g / WORD_BITS][g % WORD_BITS] = 1'b1;
          if (free_cnt != '0) begin
            free_cnt = free_cnt - 1'b1;
          end
          res.granted_block = BLK_W'(g);
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_FREE: begin
        usage_words[it.block_number / WORD_BITS][it.block_number % WORD_BITS] = 1'b0;
        if (free_cnt < block_limit) begin
          free_cnt = free_cnt + 1'b1;
        end
      end
      CMD_LOAD: begin
        usage_words[it.word_index] = it.word_data;
      end
      CMD_SET_COUNT: begin
        free_cnt = it.count_value;
      end
    endcase
    res.free_blocks = free_cnt;
    return res;
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_item, 0);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item.status !== exp_res.status) begin
          report_mismatch("status", out_item.status, exp_res.status);
        end
        if (out_item.granted_block !== exp_res.granted_block) begin
          report_mismatch("granted_block", out_item.granted_block, exp_res.granted_block);
        end
        if (out_item.free_blocks !== exp_res.free_blocks) begin
          report_mismatch("free_blocks", out_item.free_blocks, exp_res.free_blocks);
        end
      end
    end
  end

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = predict_alloc_result(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    logic [31:0] mask;
    mask = (r == REG_BLOCK_COUNT) ? ((32'd1 << CNT_W) - 1) : ((32'd1 << BMC_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_BLOCK_COUNT:  block_limit  = v[CNT_W-1:0];
      REG_BITMAP_COUNT: bitmaps_used = v[BMC_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (v & mask)) begin
      report_mismatch("register readback", prdata & mask, v & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t mk_item(cmd_e c, logic [BLK_W-1:0] blk, logic [WIN_W-1:0] widx,
                                       logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt);
    in_item_t it;
    it.command      = c;
    it.block_number = blk;
    it.word_index   = widx;
    it.word_data    = data;
    it.count_value  = cnt;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic st, logic [BLK_W-1:0] g, logic [CNT_W-1:0] f);
    out_item_t res;
    res.status        = st;
    res.granted_block = g;
    res.free_blocks   = f;
    return res;
  endfunction

  task automatic row_item(in_item_t it);
    stim_row_t row;
    row = '{kind: ROW_ITEM, reg_sel: REG_BLOCK_COUNT, reg_val: '0, item: it, typed: 1'b0,
            want: '0};
    directed.push_back(row);
  endtask

  task automatic row_checked(in_item_t it, out_item_t want);
    stim_row_t row;
    row = '{kind: ROW_ITEM, reg_sel: REG_BLOCK_COUNT, reg_val: '0, item: it, typed: 1'b1,
            want: want};
    directed.push_back(row);
  endtask

  task automatic row_cfg(reg_e r, logic [31:0] v);
    stim_row_t row;
    row = '{kind: ROW_CFG, reg_sel: r, reg_val: v, item: '0, typed: 1'b0, want: '0};
    directed.push_back(row);
  endtask

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.command      = CMD_ALLOC;
    it.block_number = BLK_W'($urandom);
    it.word_index   = WIN_W'($urandom);
    it.word_data    = $urandom;
    it.count_value  = CNT_W'($urandom_range(0, 65536));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.command = CMD_ALLOC;
    end else if (pick < 65) begin
      it.command = CMD_FREE;
      if ($urandom_range(0, 1) == 1) begin
        it.block_number = BLK_W'($urandom_range(0, 2047));
      end
    end else if (pick < 85) begin
      it.command = CMD_LOAD;
      if ($urandom_range(0, 1) == 1) begin
        it.word_index = WIN_W'($urandom_range(0, 63));
      end
      case ($urandom_range(0, 3))
        0:       it.word_data = '1;
        1:       it.word_data = '0;
        default: ;
      endcase
    end else begin
      it.command = CMD_SET_COUNT;
      if (pick == 99) begin
        it.count_value = block_limit;
      end
    end
    return it;
  endfunction

  task automatic run_mixed(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(random_item(), 1'b0, '0);
    end
  endtask

  initial begin
    in_item_t it;
    for (int i = 0; i < TOTAL_WORDS; i++) begin
      usage_words[i] = '0;
    end
    free_cnt     = '0;
    block_limit  = BLOCK_COUNT_RST;
    bitmaps_used = BITMAP_COUNT_RST;

    row_checked(mk_item(CMD_ALLOC, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF, 17'h10000),
                mk_res(1'b0, 16'd0, 17'd0));
    row_checked(mk_item(CMD_SET_COUNT, 16'd0, 11'd0, 32'd0, 17'h10000),
                mk_res(1'b0, 16'd0, 17'h10000));
    row_checked(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0),
                mk_res(1'b0, 16'd1, 17'hFFFF));
    row_checked(mk_item(CMD_FREE, 16'd0, 11'h7FF, 32'hFFFF_FFFF, 17'h10000),
                mk_res(1'b0, 16'd0, 17'h10000));
    row_checked(mk_item(CMD_FREE, 16'hFFFF, 11'd0, 32'd0, 17'd0),
                mk_res(1'b0, 16'd0, 17'h10000));
    row_checked(mk_item(CMD_LOAD, 16'hFFFF, 11'd0, 32'hFFFF_FFFF, 17'd0),
                mk_res(1'b0, 16'd0, 17'h10000));
    row_item(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0));
    row_item(mk_item(CMD_LOAD, 16'd0, 11'h7FF, 32'd0, 17'h10000));
    row_item(mk_item(CMD_LOAD, 16'd0, 11'd1, 32'h7FFF_FFFF, 17'd0));
    row_item(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0));
    row_checked(mk_item(CMD_SET_COUNT, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF, 17'd0),
                mk_res(1'b0, 16'd0, 17'd0));
    row_item(mk_item(CMD_FREE, 16'hFFFF, 11'd0, 32'd0, 17'd0));
    row_cfg(REG_BLOCK_COUNT, 32'd1);
    row_checked(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0), mk_res(1'b1, 16'd0, 17'd1));
    row_item(mk_item(CMD_FREE, 16'd0, 11'd0, 32'd0, 17'd0));
    row_item(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0));
    row_checked(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0), mk_res(1'b1, 16'd0, 17'd0));
    row_cfg(REG_BLOCK_COUNT, 32'h10000);
    row_cfg(REG_BITMAP_COUNT, 32'd0);
    row_checked(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0), mk_res(1'b1, 16'd0, 17'd0));
    row_cfg(REG_BITMAP_COUNT, 32'd15);
    row_item(mk_item(CMD_ALLOC, 16'd0, 11'd0, 32'd0, 17'd0));
    row_cfg(REG_BITMAP_COUNT, 32'd1);
    row_item(mk_item(CMD_LOAD, 16'd0, 11'd255, 32'h8000_0000, 17'd0));
    row_item(mk_item(CMD_FREE, 16'd8191, 11'd0, 32'd0, 17'd0));
    row_checked(mk_item(CMD_SET_COUNT, 16'd0, 11'd0, 32'd0, 17'h10000),
                mk_res(1'b0, 16'd0, 17'h10000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed[i].reg_sel, directed[i].reg_val);
      end else begin
        send_item(directed[i].item, directed[i].typed, directed[i].want);
      end
    end

    drain_results();
    write_reg(REG_BLOCK_COUNT, 32'h10000);
    write_reg(REG_BITMAP_COUNT, 32'd8);
    run_mixed(180);

    drain_results();
    send_idle_pct  = 53;
    recv_stall_pct = 0;
    write_reg(REG_BLOCK_COUNT, $urandom_range(1000, 60000));
    write_reg(REG_BITMAP_COUNT, $urandom_range(2, 7));
    run_mixed(85);
    drain_results();
    run_mixed(85);

    // Fill bitmap 0 completely so that allocations find no free block.
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 53;
    write_reg(REG_BITMAP_COUNT, 32'd1);
    write_reg(REG_BLOCK_COUNT, 32'h10000);
    for (int w = 0; w < WORDS_PER_BITMAP; w++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = random_item();
        it.command = CMD_ALLOC;
        send_item(it, 1'b0, '0);
      end
      it = random_item();
      it.command    = CMD_LOAD;
      it.word_index = WIN_W'(w);
      it.word_data  = '1;
      send_item(it, 1'b0, '0);
    end
    for (int i = 0; i < 20; i++) begin
      it = random_item();
      it.command = CMD_ALLOC;
      send_item(it, 1'b0, '0);
    end
    for (int i = 0; i < 30; i++) begin
      it = random_item();
      it.command      = CMD_FREE;
      it.block_number = BLK_W'($urandom_range(0, BITS_PER_BITMAP - 1));
      send_item(it, 1'b0, '0);
      it = random_item();
      it.command = CMD_ALLOC;
      send_item(it, 1'b0, '0);
    end
    for (int w = 0; w < WORDS_PER_BITMAP; w++) begin
      it = random_item();
      it.command    = CMD_LOAD;
      it.word_index = WIN_W'(w);
      if ($urandom_range(0, 7) != 0) begin
        it.word_data = '0;
      end
      send_item(it, 1'b0, '0);
    end

    drain_results();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    write_reg(REG_BLOCK_COUNT, $urandom_range(1, 600));
    write_reg(REG_BITMAP_COUNT, 32'd8);
    run_mixed(160);

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
